FILE: rtl/jpji_pkg.sv
// Package: shared constants, types and helper functions of the jog integrator.
`default_nettype none
package jpji_pkg;

    localparam logic [15:0] ANG_MOD  = 16'd36000;
    localparam logic [15:0] QUARTER  = 16'd9000;
    localparam logic [15:0] HALF_ANG = 16'd18000;
    localparam logic [15:0] TQ_ANG   = 16'd27000;
    localparam logic [13:0] EIGHTH   = 14'd4500;
    localparam logic [13:0] QUART14  = 14'd9000;

    localparam logic [63:0] PI_Q62   = 64'hC90FDAA22168C235;
    localparam logic [63:0] STEP_Q62 = PI_Q62 / 64'd18000;
    localparam logic [63:0] ONE_Q62  = 64'h4000_0000_0000_0000;
    localparam logic [63:0] RND_Q16  = 64'h0000_2000_0000_0000;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam logic signed [39:0] POS_X_RST = 40'sd814940;
    localparam logic signed [39:0] POS_Y_RST = 40'sd0;
    localparam logic signed [39:0] POS_Z_RST = 40'sd1332937;
    localparam logic signed [39:0] POS_MAX   = 40'sh7F_FFFF_FFFF;
    localparam logic signed [39:0] POS_MIN   = 40'sh80_0000_0000;

    localparam logic [3:0] LAST_TERM = 4'd12;

    localparam logic [1:0] MS_STEP = 2'd0;
    localparam logic [1:0] MS_SQ   = 2'd1;
    localparam logic [1:0] MS_TERM = 2'd2;

    typedef struct packed {
        logic       load_in;
        logic       upd_ang;
        logic [1:0] ang_sel;
        logic       half;
        logic       mul_start;
        logic [1:0] mul_sel;
        logic       x_ld;
        logic       x2_ld;
        logic       t_init;
        logic       div_start;
        logic       t_step;
        logic [3:0] term;
        logic       base_ld;
        logic       map_ld;
        logic       rot_en;
        logic [2:0] rot_idx;
        logic       pos_upd;
        logic       out_ld;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic enable;
    } t_sts;

    // Taylor term divisor: sine 2k(2k+1), cosine (2k-1)2k
    function automatic logic [9:0] f_divisor(input logic [3:0] k, input logic sine);
        logic [9:0] k2;
        k2 = {5'b0, k, 1'b0};
        if (sine) begin
            f_divisor = 10'(k2 * (k2 + 10'd1));
        end else begin
            f_divisor = 10'((k2 - 10'd1) * k2);
        end
    endfunction

    // floor((2^64-1)/d) for each Taylor divisor
    function automatic logic [63:0] f_recip(input logic [9:0] d);
        case (d)
            10'd2:   f_recip = ALL_ONES / 64'd2;
            10'd6:   f_recip = ALL_ONES / 64'd6;
            10'd12:  f_recip = ALL_ONES / 64'd12;
            10'd20:  f_recip = ALL_ONES / 64'd20;
            10'd30:  f_recip = ALL_ONES / 64'd30;
            10'd42:  f_recip = ALL_ONES / 64'd42;
            10'd56:  f_recip = ALL_ONES / 64'd56;
            10'd72:  f_recip = ALL_ONES / 64'd72;
            10'd90:  f_recip = ALL_ONES / 64'd90;
            10'd110: f_recip = ALL_ONES / 64'd110;
            10'd132: f_recip = ALL_ONES / 64'd132;
            10'd156: f_recip = ALL_ONES / 64'd156;
            10'd182: f_recip = ALL_ONES / 64'd182;
            10'd210: f_recip = ALL_ONES / 64'd210;
            10'd240: f_recip = ALL_ONES / 64'd240;
            10'd272: f_recip = ALL_ONES / 64'd272;
            10'd306: f_recip = ALL_ONES / 64'd306;
            10'd342: f_recip = ALL_ONES / 64'd342;
            10'd380: f_recip = ALL_ONES / 64'd380;
            10'd420: f_recip = ALL_ONES / 64'd420;
            10'd462: f_recip = ALL_ONES / 64'd462;
            10'd506: f_recip = ALL_ONES / 64'd506;
            10'd552: f_recip = ALL_ONES / 64'd552;
            10'd600: f_recip = ALL_ONES / 64'd600;
            default: f_recip = 64'd0;
        endcase
    endfunction

endpackage
`default_nettype wire

FILE: rtl/joystick_pose_jog_integrator_unit.sv
// Top level of the joystick pose jog integrator.
// Each request updates roll, pitch and yaw, rotates the jog velocity and adds it to a
// saturating Q.16 position; one result request follows each input request. With enable
// set an item runs six 13-term trig series that share one 64x64 multiplier, each term
// also dividing by its factorial step through a reciprocal multiply; with enable clear
// the angle and position updates are skipped. A finished result waits in an output
// register while the next input request is taken.
`default_nettype none
module joystick_pose_jog_integrator_unit import jpji_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic               i_cfg_wr_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic signed [7:0]  i_left_horizontal,
    input  wire logic signed [7:0]  i_left_vertical,
    input  wire logic signed [7:0]  i_right_horizontal,
    input  wire logic signed [7:0]  i_right_vertical,
    input  wire logic               i_forward_button,
    input  wire logic               i_backward_button,
    input  wire logic               i_roll_up_button,
    input  wire logic               i_roll_down_button,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [39:0]      o_pos_x,
    output logic signed [39:0]      o_pos_y,
    output logic signed [39:0]      o_pos_z,
    output logic        [15:0]      o_roll_angle,
    output logic        [15:0]      o_pitch_angle,
    output logic        [15:0]      o_yaw_angle
);
    t_cmd cmd;
    t_sts sts;

    jpji_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    jpji_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_left_horizontal  (i_left_horizontal),
        .i_left_vertical    (i_left_vertical),
        .i_right_horizontal (i_right_horizontal),
        .i_right_vertical   (i_right_vertical),
        .i_forward_button   (i_forward_button),
        .i_backward_button  (i_backward_button),
        .i_roll_up_button   (i_roll_up_button),
        .i_roll_down_button (i_roll_down_button),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .o_pos_x            (o_pos_x),
        .o_pos_y            (o_pos_y),
        .o_pos_z            (o_pos_z),
        .o_roll_angle       (o_roll_angle),
        .o_pitch_angle      (o_pitch_angle),
        .o_yaw_angle        (o_yaw_angle)
    );
endmodule
`default_nettype wire

FILE: rtl/jpji_mul.sv
// Iterative 64x64 unsigned multiplier, one 32x32 partial product per cycle.
`default_nettype none
module jpji_mul import jpji_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [63:0]  i_a,
    input  wire logic [63:0]  i_b,
    output logic      [127:0] o_res,
    output logic              o_done
);
    logic [1:0]   r_cnt;
    logic         r_busy;
    logic         r_done;
    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [127:0] r_acc;
    logic [31:0]  a_h;
    logic [31:0]  b_h;
    logic [63:0]  pp;
    logic [127:0] pp_sh;

    always_comb begin
        a_h = r_cnt[1] ? r_a[63:32] : r_a[31:0];
        b_h = r_cnt[0] ? r_b[63:32] : r_b[31:0];
        pp  = 64'(a_h) * 64'(b_h);
        case (r_cnt)
            2'd0:    pp_sh = {64'b0, pp};
            2'd3:    pp_sh = {pp, 64'b0};
            default: pp_sh = {32'b0, pp, 32'b0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt  <= 2'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + pp_sh;
        end
    end

    assign o_res  = r_acc;
    assign o_done = r_done;
endmodule
`default_nettype wire

FILE: rtl/jpji_div.sv
// Divider by a Taylor divisor: reciprocal multiply, then one compare-and-add correction.
`default_nettype none
module jpji_div import jpji_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [9:0]  i_den,
    input  wire logic [63:0] i_rcp,
    output logic      [63:0] o_quo,
    output logic             o_done
);
    logic         r_done;
    logic [63:0]  r_q;
    logic [10:0]  r_num_lo;
    logic [9:0]   r_den;
    logic [127:0] prod;
    logic         mul_done;
    logic [63:0]  q_est;
    logic [10:0]  qd;
    logic [10:0]  rem_est;
    logic         fix;

    jpji_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_a     (i_num),
        .i_b     (i_rcp),
        .o_res   (prod),
        .o_done  (mul_done)
    );

    // estimate is the quotient or one below; remainder < 2*den fits 11 bits
    always_comb begin
        q_est   = prod[127:64];
        qd      = 11'(q_est[10:0] * {1'b0, r_den});
        rem_est = 11'(r_num_lo - qd);
        fix     = (rem_est >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= mul_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num_lo <= i_num[10:0];
            r_den    <= i_den;
        end
        if (mul_done) begin
            r_q <= q_est + 64'(fix);
        end
    end

    assign o_quo  = r_q;
    assign o_done = r_done;
endmodule
`default_nettype wire

FILE: rtl/jpji_dp.sv
// Datapath: pose state, trig series, rotations and saturating position update.
`default_nettype none
module jpji_dp import jpji_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic               i_cfg_wr_data,
    input  wire logic signed [7:0]  i_left_horizontal,
    input  wire logic signed [7:0]  i_left_vertical,
    input  wire logic signed [7:0]  i_right_horizontal,
    input  wire logic signed [7:0]  i_right_vertical,
    input  wire logic               i_forward_button,
    input  wire logic               i_backward_button,
    input  wire logic               i_roll_up_button,
    input  wire logic               i_roll_down_button,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    output logic signed [39:0]      o_pos_x,
    output logic signed [39:0]      o_pos_y,
    output logic signed [39:0]      o_pos_z,
    output logic        [15:0]      o_roll_angle,
    output logic        [15:0]      o_pitch_angle,
    output logic        [15:0]      o_yaw_angle
);
    logic               r_enable;
    logic signed [7:0]  r_lh, r_lv, r_rh, r_rv;
    logic               r_fw, r_bw, r_ru, r_rd;
    logic signed [39:0] r_px, r_py, r_pz;
    logic        [15:0] r_roll, r_pitch, r_yaw;
    logic        [63:0] r_x, r_x2, r_t, r_s;
    logic        [17:0] r_b0, r_b1;
    logic signed [17:0] r_sin [3];
    logic signed [17:0] r_cos [3];
    logic signed [25:0] r_rv_w [6];
    logic signed [39:0] r_ox, r_oy, r_oz;
    logic        [15:0] r_oroll, r_opitch, r_oyaw;

    logic        [15:0] ang;
    logic        [1:0]  quad;
    logic        [13:0] rem;
    logic               s0;
    logic        [12:0] rp;
    logic               sine;
    logic        [63:0] mul_a, mul_b;
    logic       [127:0] mul_res;
    logic               mul_done;
    logic        [63:0] div_quo;
    logic               div_done;
    logic        [63:0] s_rnd;
    logic signed [17:0] bs, bc, sn, cs;
    logic signed [25:0] op_a, op_b;
    logic signed [17:0] c1, c2;
    logic               rsub;
    logic signed [43:0] p1, p2;
    logic signed [28:0] rsum;
    logic signed [25:0] v0, v1, v2;
    logic signed [8:0]  d_roll, d_pitch, d_yaw;

    function automatic logic [15:0] f_wrap(input logic [15:0] a, input logic signed [8:0] d);
        logic signed [17:0] s;
        s = $signed({2'b0, a}) + 18'(d);
        if (s < 0) begin
            s = s + $signed({2'b0, ANG_MOD});
        end else if (s >= $signed({2'b0, ANG_MOD})) begin
            s = s - $signed({2'b0, ANG_MOD});
        end
        f_wrap = s[15:0];
    endfunction

    function automatic logic signed [39:0] f_sat(input logic signed [39:0] p,
                                                 input logic signed [25:0] d);
        logic signed [40:0] s;
        s = 41'(p) + 41'(d);
        if (s[40] != s[39]) begin
            f_sat = s[40] ? POS_MIN : POS_MAX;
        end else begin
            f_sat = s[39:0];
        end
    endfunction

    always_comb begin
        d_roll  = r_ru ? 9'sd1 : (r_rd ? -9'sd1 : 9'sd0);
        d_pitch = -(9'(r_rv));
        d_yaw   = 9'(r_rh);
        v0 = r_fw ? 26'sd65536 : (r_bw ? -26'sd65536 : 26'sd0);
        v1 = 26'($signed({r_lh, 16'b0}));
        v2 = 26'($signed({r_lv, 16'b0}));

        case (i_cmd.ang_sel)
            2'd0:    ang = r_roll;
            2'd1:    ang = r_pitch;
            default: ang = r_yaw;
        endcase
        if (ang < QUARTER) begin
            quad = 2'd0; rem = ang[13:0];
        end else if (ang < HALF_ANG) begin
            quad = 2'd1; rem = 14'(ang - QUARTER);
        end else if (ang < TQ_ANG) begin
            quad = 2'd2; rem = 14'(ang - HALF_ANG);
        end else begin
            quad = 2'd3; rem = 14'(ang - TQ_ANG);
        end
        s0   = (rem <= EIGHTH);
        rp   = s0 ? rem[12:0] : 13'(QUART14 - rem);
        sine = i_cmd.half ? !s0 : s0;

        case (i_cmd.mul_sel)
            MS_STEP: begin mul_a = {51'b0, rp}; mul_b = STEP_Q62; end
            MS_SQ:   begin mul_a = r_x;         mul_b = r_x;      end
            default: begin mul_a = r_t;         mul_b = r_x2;     end
        endcase

        s_rnd = r_s + RND_Q16;
        bs = $signed(r_b0);
        bc = $signed(r_b1);
        case (quad)
            2'd0:    begin sn = bs;  cs = bc;  end
            2'd1:    begin sn = bc;  cs = -bs; end
            2'd2:    begin sn = -bs; cs = -bc; end
            default: begin sn = -bc; cs = bs;  end
        endcase

        case (i_cmd.rot_idx)
            3'd0: begin op_a = v1; c1 = r_cos[0]; op_b = v2; c2 = r_sin[0]; rsub = 1'b1; end
            3'd1: begin op_a = v1; c1 = r_sin[0]; op_b = v2; c2 = r_cos[0]; rsub = 1'b0; end
            3'd2: begin op_a = v0; c1 = r_cos[1]; op_b = r_rv_w[1]; c2 = r_sin[1];
                        rsub = 1'b0; end
            3'd3: begin op_a = r_rv_w[1]; c1 = r_cos[1]; op_b = v0; c2 = r_sin[1];
                        rsub = 1'b1; end
            3'd4: begin op_a = r_rv_w[2]; c1 = r_cos[2]; op_b = r_rv_w[0]; c2 = r_sin[2];
                        rsub = 1'b1; end
            default: begin op_a = r_rv_w[2]; c1 = r_sin[2]; op_b = r_rv_w[0];
                        c2 = r_cos[2]; rsub = 1'b0; end
        endcase
        p1 = op_a * c1;
        p2 = op_b * c2;
        rsum = rsub ? (29'($signed(p1[43:16])) - 29'($signed(p2[43:16])))
                    : (29'($signed(p1[43:16])) + 29'($signed(p2[43:16])));
    end

    jpji_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_res   (mul_res),
        .o_done  (mul_done)
    );

    jpji_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (mul_res[125:62]),
        .i_den   (f_divisor(i_cmd.term, sine)),
        .i_rcp   (f_recip(f_divisor(i_cmd.term, sine))),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_px     <= POS_X_RST;
            r_py     <= POS_Y_RST;
            r_pz     <= POS_Z_RST;
            r_roll   <= 16'd0;
            r_pitch  <= 16'd0;
            r_yaw    <= 16'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_enable <= i_cfg_wr_data;
            end
            if (i_cmd.upd_ang) begin
                r_roll  <= f_wrap(r_roll, d_roll);
                r_pitch <= f_wrap(r_pitch, d_pitch);
                r_yaw   <= f_wrap(r_yaw, d_yaw);
            end
            if (i_cmd.pos_upd) begin
                r_px <= f_sat(r_px, r_rv_w[4]);
                r_py <= f_sat(r_py, r_rv_w[5]);
                r_pz <= f_sat(r_pz, r_rv_w[3]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_lh <= i_left_horizontal;
            r_lv <= i_left_vertical;
            r_rh <= i_right_horizontal;
            r_rv <= i_right_vertical;
            r_fw <= i_forward_button;
            r_bw <= i_backward_button;
            r_ru <= i_roll_up_button;
            r_rd <= i_roll_down_button;
        end
        if (i_cmd.x_ld) begin
            r_x <= mul_res[63:0];
        end
        if (i_cmd.x2_ld) begin
            r_x2 <= mul_res[125:62];
        end
        if (i_cmd.t_init) begin
            r_t <= sine ? r_x : ONE_Q62;
            r_s <= sine ? r_x : ONE_Q62;
        end
        if (i_cmd.t_step) begin
            r_t <= div_quo;
            r_s <= i_cmd.term[0] ? (r_s - div_quo) : (r_s + div_quo);
        end
        if (i_cmd.base_ld) begin
            if (i_cmd.half) begin
                r_b1 <= s_rnd[63:46];
            end else begin
                r_b0 <= s_rnd[63:46];
            end
        end
        if (i_cmd.map_ld) begin
            r_sin[i_cmd.ang_sel] <= sn;
            r_cos[i_cmd.ang_sel] <= cs;
        end
        if (i_cmd.rot_en) begin
            r_rv_w[i_cmd.rot_idx] <= rsum[25:0];
        end
        if (i_cmd.out_ld) begin
            r_ox     <= r_px;
            r_oy     <= r_py;
            r_oz     <= r_pz;
            r_oroll  <= r_roll;
            r_opitch <= r_pitch;
            r_oyaw   <= r_yaw;
        end
    end

    assign o_sts.mul_done = mul_done;
    assign o_sts.div_done = div_done;
    assign o_sts.enable   = r_enable;
    assign o_pos_x       = r_ox;
    assign o_pos_y       = r_oy;
    assign o_pos_z       = r_oz;
    assign o_roll_angle  = r_oroll;
    assign o_pitch_angle = r_opitch;
    assign o_yaw_angle   = r_oyaw;
endmodule
`default_nettype wire

FILE: rtl/jpji_ctrl.sv
// Controller: sequences angle update, six trig series, rotations and output.
`default_nettype none
module jpji_ctrl import jpji_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_ANG  = 5'd1;
    localparam logic [4:0] S_XM   = 5'd2;
    localparam logic [4:0] S_XW   = 5'd3;
    localparam logic [4:0] S_X2M  = 5'd4;
    localparam logic [4:0] S_X2W  = 5'd5;
    localparam logic [4:0] S_TI   = 5'd6;
    localparam logic [4:0] S_TM   = 5'd7;
    localparam logic [4:0] S_TW   = 5'd8;
    localparam logic [4:0] S_DV   = 5'd9;
    localparam logic [4:0] S_DW   = 5'd10;
    localparam logic [4:0] S_ST   = 5'd11;
    localparam logic [4:0] S_BS   = 5'd12;
    localparam logic [4:0] S_MAP  = 5'd13;
    localparam logic [4:0] S_ROT  = 5'd14;
    localparam logic [4:0] S_POS  = 5'd15;
    localparam logic [4:0] S_DONE = 5'd16;

    logic [4:0] r_state, n_state;
    logic [1:0] r_j, n_j;
    logic       r_h, n_h;
    logic [3:0] r_k, n_k;
    logic [2:0] r_idx, n_idx;
    logic       r_ov, n_ov;

    always_comb begin
        n_state = r_state;
        n_j     = r_j;
        n_h     = r_h;
        n_k     = r_k;
        n_idx   = r_idx;
        n_ov    = r_ov;
        o_cmd   = '0;
        o_cmd.ang_sel = r_j;
        o_cmd.half    = r_h;
        o_cmd.term    = r_k;
        o_cmd.rot_idx = r_idx;
        o_cmd.mul_sel = MS_TERM;
        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = i_sts.enable ? S_ANG : S_DONE;
                end
            end
            S_ANG: begin
                o_cmd.upd_ang = 1'b1;
                n_j = 2'd0;
                n_h = 1'b0;
                n_state = S_XM;
            end
            S_XM: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_STEP;
                n_state = S_XW;
            end
            S_XW: begin
                if (i_sts.mul_done) begin
                    o_cmd.x_ld = 1'b1;
                    n_state = S_X2M;
                end
            end
            S_X2M: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_SQ;
                n_state = S_X2W;
            end
            S_X2W: begin
                if (i_sts.mul_done) begin
                    o_cmd.x2_ld = 1'b1;
                    n_state = S_TI;
                end
            end
            S_TI: begin
                o_cmd.t_init = 1'b1;
                n_k = 4'd1;
                n_state = S_TM;
            end
            S_TM: begin
                o_cmd.mul_start = 1'b1;
                n_state = S_TW;
            end
            S_TW: begin
                if (i_sts.mul_done) begin
                    n_state = S_DV;
                end
            end
            S_DV: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DW;
            end
            S_DW: begin
                if (i_sts.div_done) begin
                    n_state = S_ST;
                end
            end
            S_ST: begin
                o_cmd.t_step = 1'b1;
                if (r_k == LAST_TERM) begin
                    n_state = S_BS;
                end else begin
                    n_k = r_k + 4'd1;
                    n_state = S_TM;
                end
            end
            S_BS: begin
                o_cmd.base_ld = 1'b1;
                if (!r_h) begin
                    n_h = 1'b1;
                    n_state = S_XM;
                end else begin
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                o_cmd.map_ld = 1'b1;
                n_h = 1'b0;
                if (r_j == 2'd2) begin
                    n_idx = 3'd0;
                    n_state = S_ROT;
                end else begin
                    n_j = r_j + 2'd1;
                    n_state = S_XM;
                end
            end
            S_ROT: begin
                o_cmd.rot_en = 1'b1;
                if (r_idx == 3'd5) begin
                    n_state = S_POS;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            S_POS: begin
                o_cmd.pos_upd = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || i_out_ready) begin
                    o_cmd.out_ld = 1'b1;
                    n_ov = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_j     <= 2'd0;
            r_h     <= 1'b0;
            r_k     <= 4'd0;
            r_idx   <= 3'd0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_j     <= n_j;
            r_h     <= n_h;
            r_k     <= n_k;
            r_idx   <= n_idx;
            r_ov    <= n_ov;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
endmodule
`default_nettype wire
